### design/newest_valid_record_scanner_assert.svh
// ----------------------------------------------------------------------------
// Newest valid record scanner assertion macros
// Shared concurrent assertion forms used by the scanner modules.
// ----------------------------------------------------------------------------
`ifndef NEWEST_VALID_RECORD_SCANNER_ASSERT_SVH
`define NEWEST_VALID_RECORD_SCANNER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define NVRS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nvrs: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define NVRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nvrs: next-cycle check failed");

`endif

### design/nvrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nvrs_pkg
// Types, constants and the CRC step shared by the record scanner modules.
// ----------------------------------------------------------------------------
package nvrs_pkg;

   // Default configuration of the sector ring
   localparam int DEFAULT_SECTOR_COUNT = 512;
   localparam int DEFAULT_RECORD_BYTES = 84;

   // Field widths
   localparam int SECTOR_W = 9;
   localparam int POS_W    = 7;
   localparam int QUOT_W   = 9;
   localparam int CSR_W    = 32;

   // CRC-32, reflected
   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

   // Byte position saturates here
   localparam logic [POS_W-1:0] POS_MAX = 7'd127;

   // Register reset values
   localparam logic [31:0] MAGIC_RESET   = 32'h534F_4C41;
   localparam logic [15:0] VERSION_RESET = 16'h000B;

   // Reciprocal scaling used for the sector wrap
   localparam int RECIP_SHIFT = 20;

   // Summary queue geometry
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   // Register indexes
   typedef enum logic {
      CSR_EXPECTED_MAGIC   = 1'b0,
      CSR_EXPECTED_VERSION = 1'b1
   } csr_index_type;

   // One finished record, handed from front to back
   typedef struct packed {
      logic                ok;
      logic                scan;
      logic [31:0]         sequence_num;
      logic [SECTOR_W-1:0] sector;
      logic [QUOT_W-1:0]   wrap_quot;
   } rec_summary_type;

   // One byte of reflected CRC-32
   function automatic logic [31:0] crc_byte(input logic [31:0] acc, input logic [7:0] b);
      logic [31:0] c;
      c = acc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

### design/nvrs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nvrs_front
// Byte front end: CRC, header and check word capture, per-record verdict.
// ----------------------------------------------------------------------------
`include "newest_valid_record_scanner_assert.svh"

module nvrs_front #(
   parameter int SECTOR_COUNT = nvrs_pkg::DEFAULT_SECTOR_COUNT,
   parameter int RECORD_BYTES = nvrs_pkg::DEFAULT_RECORD_BYTES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_data_byte,
   input  logic [nvrs_pkg::SECTOR_W-1:0] req_sector_number,
   input  logic                          req_record_end,
   input  logic                          req_read_failed,
   input  logic                          req_scan_start,
   input  logic [31:0]                   expected_magic,
   input  logic [15:0]                   expected_version,
   input  logic                          q_full,
   output logic                          q_push,
   output nvrs_pkg::rec_summary_type     q_entry
);

   localparam logic [nvrs_pkg::POS_W-1:0] CrcEndPos = nvrs_pkg::POS_W'(RECORD_BYTES - 4);
   localparam logic [nvrs_pkg::POS_W-1:0] EndPos    = nvrs_pkg::POS_W'(RECORD_BYTES);
   localparam logic [nvrs_pkg::POS_W-1:0] LastPos   = nvrs_pkg::POS_W'(RECORD_BYTES - 1);
   localparam int Recip = ((1 << nvrs_pkg::RECIP_SHIFT) + SECTOR_COUNT - 1) / SECTOR_COUNT;

   // Per-record state
   logic [31:0]                  crc_ff, crc_in;
   logic [nvrs_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic [31:0]                  magic_ff, magic_in;
   logic [15:0]                  version_ff, version_in;
   logic [31:0]                  seq_ff, seq_in;
   logic [31:0]                  check_ff, check_in;
   logic                         err_ff, err_in;
   logic                         scan_pend_ff, scan_pend_in;

   logic                         accept;
   logic [31:0]                  crc_base;
   logic [nvrs_pkg::POS_W-1:0]   pos;
   logic [31:0]                  magic_base;
   logic [15:0]                  version_base;
   logic [31:0]                  seq_base;
   logic [31:0]                  check_base;
   logic                         err_base;
   logic [nvrs_pkg::POS_W-1:0]   seq_off;
   logic [nvrs_pkg::POS_W-1:0]   chk_off;
   logic                         rec_ok;
   logic [9:0]                   sector_sum;
   logic [29:0]                  quot_prod;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   // Scan start restarts the record in progress before this byte
   always_comb begin
      crc_base     = req_scan_start ? nvrs_pkg::CRC_INIT : crc_ff;
      pos          = req_scan_start ? '0 : pos_ff;
      magic_base   = req_scan_start ? '0 : magic_ff;
      version_base = req_scan_start ? '0 : version_ff;
      seq_base     = req_scan_start ? '0 : seq_ff;
      check_base   = req_scan_start ? '0 : check_ff;
      err_base     = req_scan_start ? 1'b0 : err_ff;
   end

   // Byte update: CRC, header lanes, check word lanes
   always_comb begin
      seq_off    = pos - 7'd6;
      chk_off    = pos - CrcEndPos;
      err_in     = err_base | req_read_failed;
      crc_in     = (pos < CrcEndPos) ? nvrs_pkg::crc_byte(crc_base, req_data_byte) : crc_base;
      magic_in   = magic_base;
      version_in = version_base;
      seq_in     = seq_base;
      check_in   = check_base;
      if (pos < 7'd4) begin
         magic_in[{pos[1:0], 3'b000} +: 8] = req_data_byte;
      end else if (pos < 7'd6) begin
         version_in[{pos[0], 3'b000} +: 8] = req_data_byte;
      end else if (pos < 7'd10) begin
         seq_in[{seq_off[1:0], 3'b000} +: 8] = req_data_byte;
      end
      if (pos >= CrcEndPos && pos < EndPos) begin
         check_in[{chk_off[1:0], 3'b000} +: 8] = req_data_byte;
      end
      pos_in       = (pos < nvrs_pkg::POS_MAX) ? pos + 7'd1 : pos;
      scan_pend_in = scan_pend_ff | req_scan_start;
   end

   // Record verdict and first half of the sector wrap
   always_comb begin
      rec_ok = !err_in && (pos == LastPos) && (magic_in == expected_magic) &&
               (version_in == expected_version) && (~crc_in == check_in);
      sector_sum = {1'b0, req_sector_number} + 10'd1;
      quot_prod  = 30'(sector_sum) * 30'(Recip);
      q_push                = accept && req_record_end;
      q_entry.ok            = rec_ok;
      q_entry.scan          = scan_pend_in;
      q_entry.sequence_num  = seq_in;
      q_entry.sector        = req_sector_number;
      q_entry.wrap_quot     = quot_prod[nvrs_pkg::RECIP_SHIFT +: nvrs_pkg::QUOT_W];
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= nvrs_pkg::CRC_INIT;
         pos_ff       <= '0;
         magic_ff     <= '0;
         version_ff   <= '0;
         seq_ff       <= '0;
         check_ff     <= '0;
         err_ff       <= 1'b0;
         scan_pend_ff <= 1'b0;
      end else if (accept) begin
         if (req_record_end) begin
            crc_ff       <= nvrs_pkg::CRC_INIT;
            pos_ff       <= '0;
            magic_ff     <= '0;
            version_ff   <= '0;
            seq_ff       <= '0;
            check_ff     <= '0;
            err_ff       <= 1'b0;
            scan_pend_ff <= 1'b0;
         end else begin
            crc_ff       <= crc_in;
            pos_ff       <= pos_in;
            magic_ff     <= magic_in;
            version_ff   <= version_in;
            seq_ff       <= seq_in;
            check_ff     <= check_in;
            err_ff       <= err_in;
            scan_pend_ff <= scan_pend_in;
         end
      end
   end

   // A finished record leaves the front clean
   `NVRS_ASSERT_NEXT(a_front_clear, clock, reset, q_push, pos_ff == '0 && crc_ff == nvrs_pkg::CRC_INIT && !scan_pend_ff)

endmodule

### design/nvrs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nvrs_queue
// Short queue of record summaries between front and back.
// ----------------------------------------------------------------------------
`include "newest_valid_record_scanner_assert.svh"

module nvrs_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  nvrs_pkg::rec_summary_type push_entry,
   output logic                      full,
   input  logic                      pop,
   output logic                      valid,
   output nvrs_pkg::rec_summary_type head_entry
);

   nvrs_pkg::rec_summary_type           slot_ff [nvrs_pkg::QUEUE_DEPTH];
   logic [nvrs_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff;
   logic [nvrs_pkg::QUEUE_PTR_W-1:0]    rd_ptr_ff;
   logic [nvrs_pkg::QUEUE_CNT_W-1:0]    count_ff;

   assign full       = (count_ff == nvrs_pkg::QUEUE_CNT_W'(nvrs_pkg::QUEUE_DEPTH));
   assign valid      = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   `NVRS_ASSERT_SAME(a_queue_no_overflow, clock, reset, push, !full || pop)
   `NVRS_ASSERT_SAME(a_queue_no_underflow, clock, reset, pop, valid)

endmodule

### design/nvrs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nvrs_back
// Back end: newest-record tracking, sector wrap and the result register.
// ----------------------------------------------------------------------------
`include "newest_valid_record_scanner_assert.svh"

module nvrs_back #(
   parameter int SECTOR_COUNT = nvrs_pkg::DEFAULT_SECTOR_COUNT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  nvrs_pkg::rec_summary_type     q_entry,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_record_ok,
   output logic [31:0]                   rsp_record_sequence,
   output logic                          rsp_any_found,
   output logic [nvrs_pkg::SECTOR_W-1:0] rsp_best_sector,
   output logic [31:0]                   rsp_best_sequence,
   output logic [nvrs_pkg::SECTOR_W-1:0] rsp_next_write_sector
);

   // Tracking state
   logic                          found_ff, found_in;
   logic [31:0]                   lead_seq_ff, lead_seq_in;
   logic [nvrs_pkg::SECTOR_W-1:0] best_sec_ff, best_sec_in;
   logic [nvrs_pkg::SECTOR_W-1:0] next_sec_ff, next_sec_in;

   // Result register
   logic                          rsp_valid_ff;
   logic                          rsp_ok_ff;
   logic [31:0]                   rsp_seq_ff;

   logic                          base_found;
   logic [31:0]                   base_seq;
   logic [nvrs_pkg::SECTOR_W-1:0] base_sec;
   logic [nvrs_pkg::SECTOR_W-1:0] base_next;
   logic [31:0]                   seq_diff;
   logic                          newer;
   logic                          take;
   logic [25:0]                   wrap_prod;
   logic [25:0]                   wrap_rem;

   assign q_pop = q_valid && (!rsp_valid_ff || rsp_ready);

   // Compare against the newest so far; scan start clears it first
   always_comb begin
      base_found  = q_entry.scan ? 1'b0 : found_ff;
      base_seq    = q_entry.scan ? '0 : lead_seq_ff;
      base_sec    = q_entry.scan ? '0 : best_sec_ff;
      base_next   = q_entry.scan ? nvrs_pkg::SECTOR_W'(1) : next_sec_ff;
      seq_diff    = q_entry.sequence_num - base_seq;
      newer       = (seq_diff != '0) && !seq_diff[31];
      take        = q_entry.ok && (!base_found || newer);
      wrap_prod   = 26'(q_entry.wrap_quot) * 26'(SECTOR_COUNT);
      wrap_rem    = 26'({1'b0, q_entry.sector}) + 26'd1 - wrap_prod;
      found_in    = base_found | take;
      lead_seq_in = take ? q_entry.sequence_num : base_seq;
      best_sec_in = take ? q_entry.sector : base_sec;
      next_sec_in = take ? wrap_rem[nvrs_pkg::SECTOR_W-1:0] : base_next;
   end

   // Tracking registers
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff    <= 1'b0;
         lead_seq_ff <= '0;
         best_sec_ff <= '0;
         next_sec_ff <= nvrs_pkg::SECTOR_W'(1);
      end else if (q_pop) begin
         found_ff    <= found_in;
         lead_seq_ff <= lead_seq_in;
         best_sec_ff <= best_sec_in;
         next_sec_ff <= next_sec_in;
      end
   end

   // Result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (q_pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_ok_ff  <= q_entry.ok;
         rsp_seq_ff <= q_entry.sequence_num;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_record_ok         = rsp_ok_ff;
   assign rsp_record_sequence   = rsp_seq_ff;
   assign rsp_any_found         = found_ff;
   assign rsp_best_sector       = best_sec_ff;
   assign rsp_best_sequence     = lead_seq_ff;
   assign rsp_next_write_sector = next_sec_ff;

   `NVRS_ASSERT_SAME(a_ok_means_found, clock, reset, rsp_valid_ff && rsp_ok_ff, found_ff)
   `NVRS_ASSERT_NEXT(a_scan_clears, clock, reset, q_pop && q_entry.scan && !q_entry.ok, !found_ff && best_sec_ff == '0)

endmodule

### design/newest_valid_record_scanner.sv
`timescale 1ns / 1ps
// Throughput: one record byte per cycle while the summary queue is not full.
// Result path: a record's verdict enters the summary queue as its final byte is
//   accepted; the newest-record compare runs as it is popped into the result register.
// Reset: synchronous, active high; clears the record in progress, newest tracking,
//   the summary queue and the result valid flag, and loads the register defaults.
// ----------------------------------------------------------------------------
// newest_valid_record_scanner
// Checks CRC-32 framed records per sector and tracks the newest valid one.
// ----------------------------------------------------------------------------

module newest_valid_record_scanner #(
   parameter int SECTOR_COUNT = nvrs_pkg::DEFAULT_SECTOR_COUNT,
   parameter int RECORD_BYTES = nvrs_pkg::DEFAULT_RECORD_BYTES
) (
   input  logic                          clock,
   input  logic                          reset,
   // Byte stream
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_data_byte,
   input  logic [nvrs_pkg::SECTOR_W-1:0] req_sector_number,
   input  logic                          req_record_end,
   input  logic                          req_read_failed,
   input  logic                          req_scan_start,
   // Record results
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_record_ok,
   output logic [31:0]                   rsp_record_sequence,
   output logic                          rsp_any_found,
   output logic [nvrs_pkg::SECTOR_W-1:0] rsp_best_sector,
   output logic [31:0]                   rsp_best_sequence,
   output logic [nvrs_pkg::SECTOR_W-1:0] rsp_next_write_sector,
   // Register writes
   input  logic                          csr_write_enable,
   input  logic                          csr_index,
   input  logic [nvrs_pkg::CSR_W-1:0]    csr_write_data
);

   logic [31:0]               magic_ff;
   logic [15:0]               version_ff;
   logic                      q_full;
   logic                      q_push;
   logic                      q_pop;
   logic                      q_valid;
   nvrs_pkg::rec_summary_type push_entry;
   nvrs_pkg::rec_summary_type head_entry;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff   <= nvrs_pkg::MAGIC_RESET;
         version_ff <= nvrs_pkg::VERSION_RESET;
      end else if (csr_write_enable) begin
         case (nvrs_pkg::csr_index_type'(csr_index))
            nvrs_pkg::CSR_EXPECTED_MAGIC: begin
               magic_ff <= csr_write_data;
            end
            nvrs_pkg::CSR_EXPECTED_VERSION: begin
               version_ff <= csr_write_data[15:0];
            end
            default: begin
               magic_ff <= magic_ff;
            end
         endcase
      end
   end

   nvrs_front #(
      .SECTOR_COUNT (SECTOR_COUNT),
      .RECORD_BYTES (RECORD_BYTES)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_sector_number (req_sector_number),
      .req_record_end    (req_record_end),
      .req_read_failed   (req_read_failed),
      .req_scan_start    (req_scan_start),
      .expected_magic    (magic_ff),
      .expected_version  (version_ff),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_entry           (push_entry)
   );

   nvrs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .valid      (q_valid),
      .head_entry (head_entry)
   );

   nvrs_back #(
      .SECTOR_COUNT (SECTOR_COUNT)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .q_valid               (q_valid),
      .q_entry               (head_entry),
      .q_pop                 (q_pop),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_record_ok         (rsp_record_ok),
      .rsp_record_sequence   (rsp_record_sequence),
      .rsp_any_found         (rsp_any_found),
      .rsp_best_sector       (rsp_best_sector),
      .rsp_best_sequence     (rsp_best_sequence),
      .rsp_next_write_sector (rsp_next_write_sector)
   );

endmodule

### tb/tb_newest_valid_record_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_newest_valid_record_scanner
// Streams sector records (good, corrupted, short, long and abandoned ones)
// into the scanner under several register settings and handshake loads.
// A scoreboard recomputes each record verdict and the newest-record
// tracking, and checks every result transaction field by field, in order.
// ----------------------------------------------------------------------------

module tb_newest_valid_record_scanner;

   localparam int REC_LEN     = nvrs_pkg::DEFAULT_RECORD_BYTES;
   localparam int SECTOR_CNT  = nvrs_pkg::DEFAULT_SECTOR_COUNT;
   localparam int HOLD_CYCLES = 300;
   localparam int RUN_LIMIT   = 500000;

   // One byte transaction on the input channel
   typedef struct {
      logic [7:0] data;
      logic [8:0] sector;
      logic       rec_end;
      logic       read_fail;
      logic       scan_start;
   } scan_byte_type;

   // One result transaction
   typedef struct {
      logic        rec_ok;
      logic [31:0] rec_seq;
      logic        any_found;
      logic [8:0]  best_sector;
      logic [31:0] lead_seq;
      logic [8:0]  next_sector;
   } scan_result_type;

   typedef enum int {
      REC_GOOD,
      REC_BAD_CRC,
      REC_BAD_MAGIC,
      REC_BAD_VERSION,
      REC_READ_FAIL,
      REC_SHORT,
      REC_LONG,
      REC_CUT
   } rec_kind_type;

   // -------------------------------------------------------------------------
   // Scoreboard: tracks the record in progress and the newest valid record,
   // and holds the verdicts still owed by the block
   // -------------------------------------------------------------------------
   class record_scoreboard;
      localparam int RECORD_LEN = nvrs_pkg::DEFAULT_RECORD_BYTES;
      localparam int RING_SIZE  = nvrs_pkg::DEFAULT_SECTOR_COUNT;

      logic [31:0]  cfg_magic;
      logic [15:0]  cfg_version;

      logic [31:0]  crc_acc;
      logic [6:0]   pos;
      logic [31:0]  cap_magic;
      logic [15:0]  cap_version;
      logic [31:0]  cap_seq;
      logic [31:0]  cap_check;
      bit           fail_seen;
      bit           found;
      logic [31:0]  lead_seq;
      logic [8:0]   best_sector;

      scan_result_type verdicts[$];
      int              error_count;

      function new();
         cfg_magic   = nvrs_pkg::MAGIC_RESET;
         cfg_version = nvrs_pkg::VERSION_RESET;
         clear_record();
         found       = 0;
         lead_seq    = '0;
         best_sector = '0;
         error_count = 0;
      endfunction

      // Reflected CRC-32, one byte
      static function logic [31:0] crc32_feed(logic [31:0] acc, logic [7:0] d);
         logic [31:0] c;
         c = acc ^ {24'd0, d};
         for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ 32'hEDB8_8320) : (c >> 1);
         end
         return c;
      endfunction

      function void clear_record();
         crc_acc     = 32'hFFFF_FFFF;
         pos         = '0;
         cap_magic   = '0;
         cap_version = '0;
         cap_seq     = '0;
         cap_check   = '0;
         fail_seen   = 0;
      endfunction

      function int pending();
         return verdicts.size();
      endfunction

      // Accepted byte: advance the record, and on its end queue a verdict
      function void note_byte(scan_byte_type b);
         int              p;
         logic [31:0]     diff;
         scan_result_type r;
         if (b.scan_start) begin
            found       = 0;
            lead_seq    = '0;
            best_sector = '0;
            clear_record();
         end
         p = int'(pos);
         if (b.read_fail) begin
            fail_seen = 1;
         end
         if (p < RECORD_LEN - 4) begin
            crc_acc = crc32_feed(crc_acc, b.data);
         end
         if (p < 4) begin
            cap_magic[8*p +: 8] = b.data;
         end else if (p < 6) begin
            cap_version[8*(p-4) +: 8] = b.data;
         end else if (p < 10) begin
            cap_seq[8*(p-6) +: 8] = b.data;
         end
         if (p >= RECORD_LEN - 4 && p < RECORD_LEN) begin
            cap_check[8*(p-(RECORD_LEN-4)) +: 8] = b.data;
         end
         // position saturates
         if (pos != 7'd127) begin
            pos = pos + 7'd1;
         end
         if (!b.rec_end) begin
            return;
         end

         r.rec_ok = !fail_seen && (p + 1 == RECORD_LEN) && cap_magic == cfg_magic
                    && cap_version == cfg_version && ~crc_acc == cap_check;
         // newer means a positive wrap-around difference; ties keep the older
         diff = cap_seq - lead_seq;
         if (r.rec_ok && (!found || (diff != 0 && !diff[31]))) begin
            lead_seq    = cap_seq;
            best_sector = b.sector;
            found       = 1;
         end
         r.rec_seq     = cap_seq;
         r.any_found   = found;
         r.best_sector = best_sector;
         r.lead_seq    = lead_seq;
         r.next_sector = 9'((int'(best_sector) + 1) % RING_SIZE);
         verdicts.push_back(r);
         clear_record();
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
         error_count++;
      endtask

      // Result transaction against the oldest owed verdict
      task check_result(scan_result_type got);
         scan_result_type want;
         if (verdicts.size() == 0) begin
            report_mismatch("result with no record end pending", got.rec_seq, 0);
            return;
         end
         want = verdicts.pop_front();
         if (got.rec_ok !== want.rec_ok)
            report_mismatch("record_ok", got.rec_ok, want.rec_ok);
         if (got.rec_seq !== want.rec_seq)
            report_mismatch("record_sequence", got.rec_seq, want.rec_seq);
         if (got.any_found !== want.any_found)
            report_mismatch("any_found", got.any_found, want.any_found);
         if (got.best_sector !== want.best_sector)
            report_mismatch("best_sector", got.best_sector, want.best_sector);
         if (got.lead_seq !== want.lead_seq)
            report_mismatch("best_sequence", got.lead_seq, want.lead_seq);
         if (got.next_sector !== want.next_sector)
            report_mismatch("next_write_sector", got.next_sector, want.next_sector);
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Signals
   // -------------------------------------------------------------------------
   logic                         clock;
   logic                         reset               = 1'b1;
   logic                         req_valid           = 1'b0;
   logic                         req_ready;
   logic [7:0]                   req_data_byte       = '0;
   logic [8:0]                   req_sector_number   = '0;
   logic                         req_record_end      = 1'b0;
   logic                         req_read_failed     = 1'b0;
   logic                         req_scan_start      = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_ready           = 1'b0;
   logic                         rsp_record_ok;
   logic [31:0]                  rsp_record_sequence;
   logic                         rsp_any_found;
   logic [8:0]                   rsp_best_sector;
   logic [31:0]                  rsp_best_sequence;
   logic [8:0]                   rsp_next_write_sector;
   logic                         csr_write_enable    = 1'b0;
   nvrs_pkg::csr_index_type      csr_index           = nvrs_pkg::CSR_EXPECTED_MAGIC;
   logic [nvrs_pkg::CSR_W-1:0]   csr_write_data      = '0;

   record_scoreboard sb;
   scan_result_type  seen;
   int               send_idle_pct  = 0;
   int               recv_stall_pct = 0;
   int               hold_seq       = 0;
   int               hold_seen      = 0;
   int               hold_left      = 0;
   int               cycle_count    = 0;
   int               bytes_sent     = 0;
   int               records_sent   = 0;
   logic [31:0]      last_seq       = '0;
   bit               restart_scan   = 0;

   newest_valid_record_scanner #(
      .SECTOR_COUNT (SECTOR_CNT),
      .RECORD_BYTES (REC_LEN)
   ) u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_data_byte         (req_data_byte),
      .req_sector_number     (req_sector_number),
      .req_record_end        (req_record_end),
      .req_read_failed       (req_read_failed),
      .req_scan_start        (req_scan_start),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_record_ok         (rsp_record_ok),
      .rsp_record_sequence   (rsp_record_sequence),
      .rsp_any_found         (rsp_any_found),
      .rsp_best_sector       (rsp_best_sector),
      .rsp_best_sequence     (rsp_best_sequence),
      .rsp_next_write_sector (rsp_next_write_sector),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Receiver: random stalls, plus a long hold-off when requested
   always @(posedge clock) begin
      if (hold_seen != hold_seq) begin
         hold_seen <= hold_seq;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Result monitor: sampled mid-cycle, accepted at the next rising edge
   always @(negedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen.rec_ok      = rsp_record_ok;
         seen.rec_seq     = rsp_record_sequence;
         seen.any_found   = rsp_any_found;
         seen.best_sector = rsp_best_sector;
         seen.lead_seq    = rsp_best_sequence;
         seen.next_sector = rsp_next_write_sector;
         sb.check_result(seen);
      end
   end

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------

   // One byte transaction, with random idle cycles ahead of it
   task automatic push_byte(input logic [7:0] d, input logic [8:0] sec, input bit last,
                            input bit bad_read, input bit first);
      scan_byte_type item;
      item.data       = d;
      item.sector     = sec;
      item.rec_end    = last;
      item.read_fail  = bad_read;
      item.scan_start = first;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_data_byte     <= d;
      req_sector_number <= sec;
      req_record_end    <= last;
      req_read_failed   <= bad_read;
      req_scan_start    <= first;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      sb.note_byte(item);
      bytes_sent++;
   endtask

   // Build one record of the given kind against the current registers and send it
   task automatic send_record(input rec_kind_type kind, input bit scan);
      logic [7:0]  q[$];
      logic [31:0] seq_val;
      logic [31:0] crc;
      logic [31:0] mg;
      logic [15:0] vr;
      logic [8:0]  sec;
      int          idx;
      int          keep;
      int          fail_at;
      bit          with_end;

      // sequence: wrap-around neighbors of the previous one, ties, random
      case ($urandom_range(0, 7))
         0:       seq_val = $urandom;
         1:       seq_val = last_seq + 32'd1;
         2:       seq_val = last_seq - 32'd1;
         3:       seq_val = last_seq;
         4:       seq_val = last_seq + 32'h7FFF_FFFF;
         5:       seq_val = last_seq + 32'h8000_0000;
         6:       seq_val = 32'hFFFF_FFFF;
         default: seq_val = last_seq + $urandom_range(2, 1000);
      endcase
      last_seq = seq_val;
      sec      = 9'($urandom_range(0, SECTOR_CNT - 1));
      mg       = sb.cfg_magic;
      vr       = sb.cfg_version;
      if (kind == REC_BAD_MAGIC) begin
         mg = mg ^ (32'd1 << $urandom_range(0, 31));
      end
      if (kind == REC_BAD_VERSION) begin
         vr = vr ^ (16'd1 << $urandom_range(0, 15));
      end

      // header, payload, then the inverted CRC little-endian
      for (int i = 0; i < 4; i++) q.push_back(mg[8*i +: 8]);
      for (int i = 0; i < 2; i++) q.push_back(vr[8*i +: 8]);
      for (int i = 0; i < 4; i++) q.push_back(seq_val[8*i +: 8]);
      while (q.size() < REC_LEN - 4) q.push_back(8'($urandom));
      crc = 32'hFFFF_FFFF;
      foreach (q[i]) crc = record_scoreboard::crc32_feed(crc, q[i]);
      crc = ~crc;
      for (int i = 0; i < 4; i++) q.push_back(crc[8*i +: 8]);

      case (kind)
         REC_BAD_CRC: begin
            idx    = $urandom_range(10, REC_LEN - 1);
            q[idx] = q[idx] ^ (8'd1 << $urandom_range(0, 7));
         end
         REC_SHORT, REC_CUT: begin
            keep = $urandom_range(1, REC_LEN - 1);
            while (q.size() > keep) void'(q.pop_back());
         end
         REC_LONG: begin
            repeat ($urandom_range(1, 60)) q.push_back(8'($urandom));
         end
         default: ;
      endcase

      fail_at  = (kind == REC_READ_FAIL) ? $urandom_range(0, q.size() - 1) : -1;
      with_end = (kind != REC_CUT);
      foreach (q[i]) begin
         push_byte(q[i], sec, with_end && i == q.size() - 1, i == fail_at, scan && i == 0);
      end
      if (with_end) begin
         records_sent++;
      end
   endtask

   // Mostly well-formed records, some broken ones; an abandoned record is
   // followed by a scan start
   task automatic run_random(input int min_bytes, input int min_records);
      int           b0;
      int           r0;
      int           roll;
      rec_kind_type kind;
      b0 = bytes_sent;
      r0 = records_sent;
      while (bytes_sent - b0 < min_bytes || records_sent - r0 < min_records) begin
         roll = $urandom_range(0, 99);
         if (roll < 55)      kind = REC_GOOD;
         else if (roll < 62) kind = REC_BAD_CRC;
         else if (roll < 67) kind = REC_BAD_MAGIC;
         else if (roll < 72) kind = REC_BAD_VERSION;
         else if (roll < 77) kind = REC_READ_FAIL;
         else if (roll < 87) kind = REC_SHORT;
         else if (roll < 93) kind = REC_LONG;
         else                kind = REC_CUT;
         send_record(kind, restart_scan || $urandom_range(0, 9) == 0);
         restart_scan = (kind == REC_CUT);
      end
   endtask

   // Wait for every owed result, then let the pipeline empty
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Both registers, written back to back while idle
   task automatic write_config(input logic [31:0] magic_val, input logic [15:0] version_val);
      csr_write_enable <= 1'b1;
      csr_index        <= nvrs_pkg::CSR_EXPECTED_MAGIC;
      csr_write_data   <= magic_val;
      @(posedge clock);
      csr_index        <= nvrs_pkg::CSR_EXPECTED_VERSION;
      csr_write_data   <= {16'd0, version_val};
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.cfg_magic   = magic_val;
      sb.cfg_version = version_val;
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      logic [79:0] hdr;
      sb  = new();
      hdr = {32'hFFFF_FFFF, nvrs_pkg::VERSION_RESET, nvrs_pkg::MAGIC_RESET};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: register defaults, no idling
      // one-byte record that opens a scan, on the last sector, with a failed read
      push_byte(8'hFF, 9'd511, 1'b1, 1'b1, 1'b1);
      // one-byte record, everything zero
      push_byte(8'h00, 9'd0, 1'b1, 1'b0, 1'b0);
      // short record with a full matching header and the top sequence
      for (int i = 0; i < 10; i++) begin
         push_byte(hdr[8*i +: 8], 9'd511, i == 9, 1'b0, i == 0);
      end
      // abandoned record, then a scan start restarts it
      for (int i = 0; i < 5; i++) begin
         push_byte(hdr[8*i +: 8], 9'd256, 1'b0, 1'b0, 1'b0);
      end
      for (int i = 0; i < 3; i++) begin
         push_byte(8'h5A << i, 9'd1, i == 2, 1'b0, i == 0);
      end
      // read error in the middle of a record
      for (int i = 0; i < 4; i++) begin
         push_byte(8'hA5, 9'd170, i == 3, i == 1, 1'b0);
      end

      // Random, defaults, no idling
      run_random(120, 1);
      settle();

      // Low extremes, sender idling
      write_config(32'h0000_0000, 16'h0000);
      send_idle_pct = 64;
      run_random(120, 1);
      settle();

      // High extremes, receiver stalling
      write_config(32'hFFFF_FFFF, 16'hFFFF);
      send_idle_pct  = 0;
      recv_stall_pct = 64;
      run_random(120, 1);
      settle();

      // Random registers, both sides idling; long receiver hold-off while
      // one-byte records keep coming, so the block backs up into its input
      write_config($urandom, 16'($urandom));
      send_idle_pct  = 29;
      recv_stall_pct = 29;
      run_random(90, 1);
      hold_seq <= hold_seq + 1;
      repeat (12) begin
         push_byte(8'($urandom), 9'($urandom), 1'b1, 1'b0, 1'b0);
      end
      run_random(90, 1);
      settle();

      // Back to the defaults, no idling; sender pauses for every result midway
      write_config(nvrs_pkg::MAGIC_RESET, nvrs_pkg::VERSION_RESET);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      run_random(90, 1);
      settle();
      run_random(90, 1);
      settle();

      repeat (20) @(posedge clock);
      if (sb.error_count == 0 && sb.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

### newest_valid_record_scanner.f
+incdir+design
design/nvrs_pkg.sv
design/nvrs_front.sv
design/nvrs_queue.sv
design/nvrs_back.sv
design/newest_valid_record_scanner.sv
tb/tb_newest_valid_record_scanner.sv
